### hw/rtl/gmc_pkg.sv
// shared types, constants and helper functions of the grid maze carver
package gmc_pkg;

  localparam int GRID_W = 31;
  localparam int GRID_H = 31;
  localparam int COORD_W = 5;
  localparam int EXT_W = COORD_W + 1;
  localparam int COL_AW = $clog2(GRID_W);
  localparam int ROW_AW = $clog2(GRID_H);
  localparam int CFG_W = 5;
  localparam int HUNT_LAST = ((GRID_H - 3) / 2) * 2 + 1;

  typedef logic [GRID_W-1:0] row_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [EXT_W-1:0] ext_t;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_START_COL = 2'd0,
    REG_START_ROW = 2'd1,
    REG_GOAL_COL  = 2'd2,
    REG_GOAL_ROW  = 2'd3
  } cfg_reg_t;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef struct packed {
    logic has_up;
    logic has_down;
  } scan_ctl_t;

  typedef struct packed {
    logic   found;
    coord_t col;
  } scan_res_t;

  function automatic logic cell_bit(row_t r, ext_t c);
    logic b;
    b = 1'b1;
    if (c < ext_t'(GRID_W)) b = r[c[COL_AW-1:0]];
    return b;
  endfunction

  function automatic row_t clear_bit(row_t r, coord_t c);
    row_t m;
    m = '0;
    if (c < coord_t'(GRID_W)) m[c[COL_AW-1:0]] = 1'b1;
    return r & ~m;
  endfunction

  function automatic logic interior_col(ext_t c);
    return (c != '0) && (c < ext_t'(GRID_W - 1));
  endfunction

  function automatic logic interior_row(ext_t r);
    return (r != '0) && (r < ext_t'(GRID_H - 1));
  endfunction

endpackage

### hw/rtl/gmc_ram.sv
// generic single write port, single read port ram with registered read
module gmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/gmc_scan.sv
// hunt search over a three row window: first open odd cell with a walled neighbor
module gmc_scan (
  input  gmc_pkg::row_t      prev_row,
  input  gmc_pkg::row_t      cur_row,
  input  gmc_pkg::row_t      next_row,
  input  gmc_pkg::scan_ctl_t ctl,
  output gmc_pkg::scan_res_t res
);

  always_comb begin
    int  k;
    logic up, down, left, right;
    res = '0;
    for (int j = (gmc_pkg::GRID_W - 3) / 2; j >= 0; j--) begin
      k = 2 * j + 1;
      up = ctl.has_up && prev_row[k];
      down = ctl.has_down && next_row[k];
      left = (k >= 3) ? cur_row[k-2] : 1'b0;
      right = (k + 2 <= gmc_pkg::GRID_W - 2) ? cur_row[k+2] : 1'b0;
      if (!cur_row[k] && (up || down || left || right)) begin
        res.found = 1'b1;
        res.col = gmc_pkg::coord_t'(k);
      end
    end
  end

endmodule

### hw/rtl/grid_maze_carver.sv
// top level of the grid maze carver: command sequencer around one row ram
// Hunt-and-kill maze generator over a 31 x 31 wall bitmap held one row per word in a
// single-port-read ram; a row valid flop per row makes every row read as all wall after
// reset or a clear command, so clearing takes no sweep. One item is taken at a time and
// its result is held on the output until taken; the block is not ready meanwhile. All
// work goes through the one ram read port. A clear opens the start cell with a read and
// a write of its row, and a read fetches the probed row and then checks the cell. A step
// tries up to four shuffled directions, each a row read then a check; on a hit it opens
// the wall and the new cell with a read and write each, else it hunts over the odd rows
// (up to 15) and at the finish opens start and goal. A taken result returns it to idle.
module grid_maze_carver (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_en,
  input  logic [1:0]                             cfg_index,
  input  logic [gmc_pkg::CFG_W-1:0]              cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             cmd,
  input  logic [1:0]                             draw_first,
  input  logic [1:0]                             draw_second,
  input  logic                                   draw_third,
  input  logic [gmc_pkg::COORD_W-1:0]            probe_col,
  input  logic [gmc_pkg::COORD_W-1:0]            probe_row,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [gmc_pkg::COORD_W-1:0]            walker_col,
  output logic [gmc_pkg::COORD_W-1:0]            walker_row,
  output logic                                   carved,
  output logic                                   jumped,
  output logic                                   finished,
  output logic                                   cell_is_wall
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DIR_RD    = 11'b000_0000_0010,
    ST_DIR_CHK   = 11'b000_0000_0100,
    ST_HUNT_PRE  = 11'b000_0000_1000,
    ST_HUNT_RD   = 11'b000_0001_0000,
    ST_HUNT_CHK  = 11'b000_0010_0000,
    ST_OPEN_RD   = 11'b000_0100_0000,
    ST_OPEN_WR   = 11'b000_1000_0000,
    ST_PROBE_RD  = 11'b001_0000_0000,
    ST_PROBE_CHK = 11'b010_0000_0000,
    ST_OUT       = 11'b100_0000_0000
  } state_t;

  typedef struct packed {
    gmc_pkg::ext_t   nx;
    gmc_pkg::ext_t   ny;
    gmc_pkg::coord_t mx;
    gmc_pkg::coord_t my;
  } nbr_t;

  function automatic logic [3:0][1:0] shuffle(logic [1:0] j1, logic [1:0] j2, logic j3);
    logic [3:0][1:0] d;
    logic [1:0] t;
    d[0] = gmc_pkg::DIR_UP;
    d[1] = gmc_pkg::DIR_DOWN;
    d[2] = gmc_pkg::DIR_LEFT;
    d[3] = gmc_pkg::DIR_RIGHT;
    t = d[3]; d[3] = d[j1]; d[j1] = t;
    t = d[2]; d[2] = d[j2]; d[j2] = t;
    t = d[1]; d[1] = d[{1'b0, j3}]; d[{1'b0, j3}] = t;
    return d;
  endfunction

  function automatic nbr_t neighbor(logic [1:0] dir, gmc_pkg::coord_t x, gmc_pkg::coord_t y);
    nbr_t n;
    n.nx = gmc_pkg::ext_t'(x);
    n.ny = gmc_pkg::ext_t'(y);
    n.mx = x;
    n.my = y;
    unique case (dir)
      gmc_pkg::DIR_UP: begin
        n.ny = gmc_pkg::ext_t'(y) - gmc_pkg::ext_t'(2);
        n.my = y - gmc_pkg::coord_t'(1);
      end
      gmc_pkg::DIR_DOWN: begin
        n.ny = gmc_pkg::ext_t'(y) + gmc_pkg::ext_t'(2);
        n.my = y + gmc_pkg::coord_t'(1);
      end
      gmc_pkg::DIR_LEFT: begin
        n.nx = gmc_pkg::ext_t'(x) - gmc_pkg::ext_t'(2);
        n.mx = x - gmc_pkg::coord_t'(1);
      end
      gmc_pkg::DIR_RIGHT: begin
        n.nx = gmc_pkg::ext_t'(x) + gmc_pkg::ext_t'(2);
        n.mx = x + gmc_pkg::coord_t'(1);
      end
      default: ;
    endcase
    return n;
  endfunction

  state_t state, state_next;

  gmc_pkg::coord_t start_col, start_row, goal_col, goal_row;
  gmc_pkg::coord_t walker_x, walker_y;
  logic [gmc_pkg::GRID_H-1:0] row_valid;

  logic [3:0][1:0] dirs;
  logic [1:0] slot;
  gmc_pkg::ext_t hunt_row;
  gmc_pkg::row_t prev_row, cur_row;
  gmc_pkg::coord_t t0_col, t0_row, t1_col, t1_row;
  logic more;
  gmc_pkg::coord_t probe_col_q, probe_row_q;
  logic rvalid_q;

  gmc_pkg::ext_t rd_row;
  gmc_pkg::row_t rd_data, eff_row, wr_data;
  logic wr_en;
  logic t0_on_grid;
  nbr_t nb;
  logic dir_hit;
  logic hunt_last;
  gmc_pkg::scan_ctl_t scan_ctl;
  gmc_pkg::scan_res_t scan_res;

  assign in_ready = (state == ST_IDLE);
  assign out_valid = (state == ST_OUT);
  assign walker_col = walker_x;
  assign walker_row = walker_y;

  assign eff_row = rvalid_q ? rd_data : '1;
  assign nb = neighbor(dirs[slot], walker_x, walker_y);
  assign dir_hit = gmc_pkg::interior_col(nb.nx) && gmc_pkg::interior_row(nb.ny)
                   && gmc_pkg::cell_bit(eff_row, nb.nx);
  assign hunt_last = (hunt_row == gmc_pkg::ext_t'(gmc_pkg::HUNT_LAST));
  assign scan_ctl.has_up = (hunt_row >= gmc_pkg::ext_t'(3));
  assign scan_ctl.has_down = (hunt_row <= gmc_pkg::ext_t'(gmc_pkg::GRID_H - 4));
  assign t0_on_grid = (t0_col < gmc_pkg::coord_t'(gmc_pkg::GRID_W))
                      && (t0_row < gmc_pkg::coord_t'(gmc_pkg::GRID_H));
  assign wr_en = (state == ST_OPEN_WR) && t0_on_grid;
  assign wr_data = gmc_pkg::clear_bit(eff_row, t0_col);

  gmc_ram #(
    .WIDTH(gmc_pkg::GRID_W),
    .DEPTH(gmc_pkg::GRID_H)
  ) u_rows (
    .clk  (clk),
    .we   (wr_en),
    .waddr(t0_row[gmc_pkg::ROW_AW-1:0]),
    .wdata(wr_data),
    .raddr(rd_row[gmc_pkg::ROW_AW-1:0]),
    .rdata(rd_data)
  );

  gmc_scan u_scan (
    .prev_row(prev_row),
    .cur_row (cur_row),
    .next_row(eff_row),
    .ctl     (scan_ctl),
    .res     (scan_res)
  );

  always_comb begin
    rd_row = '0;
    unique case (state)
      ST_DIR_RD:   rd_row = nb.ny;
      ST_HUNT_PRE: rd_row = hunt_row;
      ST_HUNT_RD:  rd_row = hunt_row + gmc_pkg::ext_t'(2);
      ST_HUNT_CHK: rd_row = hunt_row + gmc_pkg::ext_t'(4);
      ST_OPEN_RD:  rd_row = gmc_pkg::ext_t'(t0_row);
      ST_PROBE_RD: rd_row = gmc_pkg::ext_t'(probe_row_q);
      default:     rd_row = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (gmc_pkg::cmd_t'(cmd))
            gmc_pkg::CMD_CLEAR: state_next = ST_OPEN_RD;
            gmc_pkg::CMD_STEP:  state_next = ST_DIR_RD;
            gmc_pkg::CMD_READ:  state_next = ST_PROBE_RD;
            default:            state_next = ST_OUT;
          endcase
        end
      end
      ST_DIR_RD: state_next = ST_DIR_CHK;
      ST_DIR_CHK: begin
        if (dir_hit) state_next = ST_OPEN_RD;
        else if (&slot) state_next = ST_HUNT_PRE;
        else state_next = ST_DIR_RD;
      end
      ST_HUNT_PRE: state_next = ST_HUNT_RD;
      ST_HUNT_RD:  state_next = ST_HUNT_CHK;
      ST_HUNT_CHK: begin
        if (scan_res.found) state_next = ST_OUT;
        else if (hunt_last) state_next = ST_OPEN_RD;
      end
      ST_OPEN_RD: state_next = ST_OPEN_WR;
      ST_OPEN_WR: state_next = more ? ST_OPEN_RD : ST_OUT;
      ST_PROBE_RD: state_next = ST_PROBE_CHK;
      ST_PROBE_CHK: state_next = ST_OUT;
      ST_OUT: begin
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      walker_x <= gmc_pkg::coord_t'(1);
      walker_y <= gmc_pkg::coord_t'(1);
      row_valid <= '0;
      start_col <= gmc_pkg::coord_t'(1);
      start_row <= gmc_pkg::coord_t'(1);
      goal_col <= gmc_pkg::coord_t'(29);
      goal_row <= gmc_pkg::coord_t'(29);
    end else begin
      state <= state_next;
      if (cfg_en) begin
        unique case (gmc_pkg::cfg_reg_t'(cfg_index))
          gmc_pkg::REG_START_COL: start_col <= cfg_data;
          gmc_pkg::REG_START_ROW: start_row <= cfg_data;
          gmc_pkg::REG_GOAL_COL:  goal_col <= cfg_data;
          gmc_pkg::REG_GOAL_ROW:  goal_row <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid && gmc_pkg::cmd_t'(cmd) == gmc_pkg::CMD_CLEAR) begin
            row_valid <= '0;
            walker_x <= start_col;
            walker_y <= start_row;
          end
        end
        ST_DIR_CHK: begin
          if (dir_hit) begin
            walker_x <= nb.nx[gmc_pkg::COORD_W-1:0];
            walker_y <= nb.ny[gmc_pkg::COORD_W-1:0];
          end
        end
        ST_HUNT_CHK: begin
          if (scan_res.found) begin
            walker_x <= scan_res.col;
            walker_y <= hunt_row[gmc_pkg::COORD_W-1:0];
          end
        end
        ST_OPEN_WR: begin
          if (t0_on_grid) row_valid[t0_row[gmc_pkg::ROW_AW-1:0]] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rvalid_q <= (rd_row < gmc_pkg::ext_t'(gmc_pkg::GRID_H))
                && row_valid[rd_row[gmc_pkg::ROW_AW-1:0]];
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          dirs <= shuffle(draw_first, (draw_second > 2'd2) ? 2'd2 : draw_second, draw_third);
          slot <= '0;
          hunt_row <= gmc_pkg::ext_t'(1);
          probe_col_q <= probe_col;
          probe_row_q <= probe_row;
          t0_col <= start_col;
          t0_row <= start_row;
          more <= 1'b0;
          carved <= 1'b0;
          jumped <= 1'b0;
          finished <= 1'b0;
          cell_is_wall <= 1'b0;
        end
      end
      ST_DIR_CHK: begin
        if (dir_hit) begin
          carved <= 1'b1;
          t0_col <= nb.mx;
          t0_row <= nb.my;
          t1_col <= nb.nx[gmc_pkg::COORD_W-1:0];
          t1_row <= nb.ny[gmc_pkg::COORD_W-1:0];
          more <= 1'b1;
        end else begin
          slot <= slot + 2'd1;
        end
      end
      ST_HUNT_RD: begin
        prev_row <= '1;
        cur_row <= eff_row;
      end
      ST_HUNT_CHK: begin
        if (scan_res.found) begin
          jumped <= 1'b1;
        end else if (hunt_last) begin
          finished <= 1'b1;
          t0_col <= start_col;
          t0_row <= start_row;
          t1_col <= goal_col;
          t1_row <= goal_row;
          more <= 1'b1;
        end else begin
          prev_row <= cur_row;
          cur_row <= eff_row;
          hunt_row <= hunt_row + gmc_pkg::ext_t'(2);
        end
      end
      ST_OPEN_WR: begin
        if (more) begin
          t0_col <= t1_col;
          t0_row <= t1_row;
          more <= 1'b0;
        end
      end
      ST_PROBE_CHK: begin
        cell_is_wall <= gmc_pkg::cell_bit(eff_row, gmc_pkg::ext_t'(probe_col_q));
      end
      default: ;
    endcase
  end

endmodule

### hw/rtl/gmc_checker.sv
// port level checks of the grid maze carver and their binding to the top level
module gmc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [gmc_pkg::COORD_W-1:0]   walker_col,
  input logic [gmc_pkg::COORD_W-1:0]   walker_row,
  input logic                          carved,
  input logic                          jumped,
  input logic                          finished,
  input logic                          cell_is_wall
);

  // one item in flight at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready right after an accepted item");

  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({carved, jumped, finished, cell_is_wall}))
    else $error("more than one outcome flag set");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(walker_col) && $stable(walker_row))
    else $error("result changed while stalled");

endmodule

bind grid_maze_carver gmc_checker u_gmc_checker (.*);
